// ===== sv/ipv6_literal_validator_macros.svh =====
// Assertion macros shared by the validator RTL.
`ifndef IPV6_LITERAL_VALIDATOR_MACROS_SVH
`define IPV6_LITERAL_VALIDATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IPV6LV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipv6lv assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IPV6LV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipv6lv assertion failed");

`endif

// ===== sv/ipv6lv_pkg.sv =====
`timescale 1ns / 1ps

package ipv6lv_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic [3:0] MAX_GROUPS     = 4'd8;
  localparam logic [2:0] HEX_GROUP_MAX  = 3'd4;
  localparam logic [2:0] DEC_MAX_DIGITS = 3'd3;
  localparam logic [9:0] DEC_MAX_VALUE  = 10'd255;
  localparam logic [2:0] DOTS_NEEDED    = 3'd3;

  typedef struct packed {
    logic       failed;
    logic       at_start;
    logic       pending_colon;
    logic       double_colon_seen;
    logic [2:0] group_length;
    logic       group_all_hex;
    logic       group_has_dot;
    logic [3:0] group_total;
    logic [2:0] dotted_part_count;
    logic [2:0] dotted_digit_count;
    logic [9:0] dotted_part_value;
    logic       dotted_bad;
  } state_t;

  localparam state_t STATE_RESET = '{
    failed:             1'b0,
    at_start:           1'b1,
    pending_colon:      1'b0,
    double_colon_seen:  1'b0,
    group_length:       3'd0,
    group_all_hex:      1'b1,
    group_has_dot:      1'b0,
    group_total:        4'd0,
    dotted_part_count:  3'd0,
    dotted_digit_count: 3'd0,
    dotted_part_value:  10'd0,
    dotted_bad:         1'b0
  };

endpackage

// ===== sv/ipv6lv_step.sv =====
`timescale 1ns / 1ps

module ipv6lv_step (
  input  ipv6lv_pkg::state_t state_cur,
  input  logic [7:0]         character,
  input  logic               last,
  output ipv6lv_pkg::state_t state_nxt,
  output logic               valid_res_nxt
);

  function automatic logic [2:0] sat_inc3(input logic [2:0] v);
    return (v == 3'd7) ? 3'd7 : v + 3'd1;
  endfunction

  function automatic logic [3:0] sat_add4(input logic [3:0] v, input logic [1:0] a);
    logic [4:0] s;
    s = {1'b0, v} + {3'b000, a};
    return s[4] ? 4'd15 : s[3:0];
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Close a non-empty group; a dotted group is legal only as the final one.
  function automatic ipv6lv_pkg::state_t close_group(input ipv6lv_pkg::state_t s,
                                                     input logic final_group);
    ipv6lv_pkg::state_t r;
    r = s;
    if (s.group_has_dot) begin
      if (!final_group || s.dotted_bad || s.dotted_digit_count == 3'd0 ||
          s.dotted_part_count != ipv6lv_pkg::DOTS_NEEDED) begin
        r.failed = 1'b1;
      end else begin
        r.group_total = sat_add4(s.group_total, 2'd2);
      end
    end else begin
      if (s.group_length > ipv6lv_pkg::HEX_GROUP_MAX || !s.group_all_hex) begin
        r.failed = 1'b1;
      end else begin
        r.group_total = sat_add4(s.group_total, 2'd1);
      end
    end
    r.group_length       = 3'd0;
    r.group_all_hex      = 1'b1;
    r.group_has_dot      = 1'b0;
    r.dotted_part_count  = 3'd0;
    r.dotted_digit_count = 3'd0;
    r.dotted_part_value  = 10'd0;
    r.dotted_bad         = 1'b0;
    return r;
  endfunction

  ipv6lv_pkg::state_t s;
  logic               is_digit;
  logic [9:0]         value_x10;
  logic [9:0]         value_new;
  logic [2:0]         digits_new;

  always_comb begin
    is_digit   = (character >= ipv6lv_pkg::CH_ZERO) && (character <= ipv6lv_pkg::CH_NINE);
    value_x10  = {state_cur.dotted_part_value[6:0], 3'b000} +
                 {state_cur.dotted_part_value[8:0], 1'b0};
    value_new  = value_x10 + {6'd0, character[3:0]};
    digits_new = sat_inc3(state_cur.dotted_digit_count);

    s = state_cur;
    valid_res_nxt = 1'b0;

    if (character == ipv6lv_pkg::CH_PERCENT) begin
      s.failed = 1'b1;
    end else if (character == ipv6lv_pkg::CH_COLON) begin
      if (state_cur.pending_colon) begin
        if (state_cur.double_colon_seen) begin
          s.failed = 1'b1;
        end
        s.double_colon_seen = 1'b1;
        s.pending_colon     = 1'b0;
        s.at_start          = 1'b0;
      end else if (state_cur.at_start) begin
        s.pending_colon = 1'b1;
      end else if (state_cur.group_length == 3'd0) begin
        s.failed = 1'b1;
      end else begin
        s = close_group(state_cur, 1'b0);
        s.pending_colon = 1'b1;
      end
    end else begin
      if (state_cur.pending_colon && state_cur.at_start) begin
        s.failed = 1'b1;
      end
      s.pending_colon = 1'b0;
      s.at_start      = 1'b0;
      s.group_length  = sat_inc3(state_cur.group_length);
      if (!is_hex(character)) begin
        s.group_all_hex = 1'b0;
      end
      if (character == ipv6lv_pkg::CH_DOT) begin
        s.group_has_dot = 1'b1;
        if (state_cur.dotted_digit_count == 3'd0) begin
          s.dotted_bad = 1'b1;
        end
        s.dotted_part_count  = sat_inc3(state_cur.dotted_part_count);
        s.dotted_digit_count = 3'd0;
        s.dotted_part_value  = 10'd0;
      end else if (is_digit) begin
        s.dotted_digit_count = digits_new;
        if (digits_new > ipv6lv_pkg::DEC_MAX_DIGITS) begin
          s.dotted_bad = 1'b1;
        end else begin
          s.dotted_part_value = value_new;
          if (value_new > ipv6lv_pkg::DEC_MAX_VALUE) begin
            s.dotted_bad = 1'b1;
          end
        end
      end else begin
        s.dotted_bad = 1'b1;
      end
    end

    if (last) begin
      if (s.pending_colon) begin
        s.failed = 1'b1;
      end
      if (s.group_length != 3'd0) begin
        s = close_group(s, 1'b1);
      end
      if (s.double_colon_seen) begin
        if (s.group_total >= ipv6lv_pkg::MAX_GROUPS) begin
          s.failed = 1'b1;
        end
      end else if (s.group_total != ipv6lv_pkg::MAX_GROUPS) begin
        s.failed = 1'b1;
      end
      valid_res_nxt = !s.failed;
      state_nxt     = ipv6lv_pkg::STATE_RESET;
    end else begin
      state_nxt = s;
    end
  end

endmodule

// ===== sv/ipv6_literal_validator.sv =====
`timescale 1ns / 1ps
// Checks IPv6 address text fed one ASCII character per request, the final
// character flagged by in_last, and returns one request carrying out_valid_res
// after each flagged character (1 = valid literal, '%' anywhere rejects).
// One character is taken every cycle while in_stall is low; a character is
// held in the input register, where the running parse state is updated,
// and the verdict of a flagged character is then written to the result register.
// The input side stalls only when a flagged character waits while a previous
// verdict is still held by a stalled consumer.

`include "ipv6_literal_validator_macros.svh"

module ipv6_literal_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_valid_res
);

  logic               in_vld_r;
  logic [7:0]         in_char_r;
  logic               in_last_r;
  ipv6lv_pkg::state_t state_r;
  ipv6lv_pkg::state_t state_nxt;
  logic               out_vld_r;
  logic               out_res_r;
  logic               res_nxt;
  logic               adv;
  logic               in_take;

  ipv6lv_step u_step (
    .state_cur     (state_r),
    .character     (in_char_r),
    .last          (in_last_r),
    .state_nxt     (state_nxt),
    .valid_res_nxt (res_nxt)
  );

  assign adv      = in_vld_r && (!in_last_r || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      state_r   <= ipv6lv_pkg::STATE_RESET;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        state_r <= state_nxt;
      end
      if (adv && in_last_r) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char_r <= in_character;
      in_last_r <= in_last;
    end
    if (adv && in_last_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_valid_res = out_res_r;

  `IPV6LV_ASSERT_NXT(a_hold_blocked, in_vld_r && !adv, in_vld_r && $stable(in_char_r))
  `IPV6LV_ASSERT_NXT(a_verdict_follows, adv && in_last_r, out_vld_r)
  `IPV6LV_ASSERT_NXT(a_state_cleared, adv && in_last_r, state_r == ipv6lv_pkg::STATE_RESET)
  `IPV6LV_ASSERT_IMP(a_no_overwrite, out_vld_r && out_stall, !(adv && in_last_r))

endmodule
